>>> design/dma_4d_descriptor_address_generator_defines.svh
// Assertion macros used by the address generator top module.
`ifndef DMA_4D_DESCRIPTOR_ADDRESS_GENERATOR_DEFINES_SVH
`define DMA_4D_DESCRIPTOR_ADDRESS_GENERATOR_DEFINES_SVH

// Same-cycle implication, sampled on clk, off while rst_n is low.
`define D4DAG_ASSERT_IMPL(name, ante, cons, msg) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, sampled on clk, off while rst_n is low.
`define D4DAG_ASSERT_NEXT(name, ante, cons, msg) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

>>> design/d4dag_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package d4dag_pkg;

    // Sizing
    localparam int SLOTS      = 16;
    localparam int ADDR_BITS  = 16;
    localparam int COUNT_BITS = 16;
    localparam int DIMS       = 4;
    localparam int VALUE_BITS = 16;
    localparam int SLOT_BITS  = (SLOTS > 1) ? $clog2(SLOTS) : 1;

    // Reciprocal for reducing a written link modulo SLOTS
    localparam int MOD_SHIFT      = VALUE_BITS + SLOT_BITS;
    localparam int MOD_RECIP_BITS = MOD_SHIFT + 1;
    localparam logic [MOD_RECIP_BITS-1:0] MOD_RECIP =
        MOD_RECIP_BITS'((64'd1 << MOD_SHIFT) / SLOTS);
    localparam int MOD_PROD_BITS  = VALUE_BITS + MOD_RECIP_BITS;
    localparam int MOD_QS_BITS    = VALUE_BITS + 1;

    typedef logic [SLOT_BITS-1:0]                  slot_t;
    typedef logic [ADDR_BITS-1:0]                  addr_t;
    typedef logic [COUNT_BITS-1:0]                 count_t;
    typedef logic [DIMS-1:0][COUNT_BITS-1:0]       count_vec_t;
    typedef logic [DIMS-1:0][ADDR_BITS-1:0]        step_vec_t;

    typedef enum logic [1:0] {
        MODE_SUSPEND  = 2'd0,
        MODE_TRANSFER = 2'd1,
        MODE_FORWARD  = 2'd2,
        MODE_WAIT     = 2'd3
    } mode_t;

    // Request opcodes
    localparam logic [1:0] OP_TICK  = 2'd0;
    localparam logic [1:0] OP_WRITE = 2'd1;
    localparam logic [1:0] OP_START = 2'd2;

    // Access kinds
    localparam logic [1:0] ACC_NONE  = 2'd0;
    localparam logic [1:0] ACC_READ  = 2'd1;
    localparam logic [1:0] ACC_WRITE = 2'd2;
    localparam logic [1:0] ACC_ZERO  = 2'd3;

    // Descriptor word selectors
    localparam logic [3:0] WORD_NEXT   = 4'd0;
    localparam logic [3:0] WORD_START  = 4'd1;
    localparam logic [3:0] WORD_MODE   = 4'd2;
    localparam logic [3:0] WORD_XCOUNT = 4'd3;
    localparam logic [3:0] WORD_XSTEP  = 4'd4;
    localparam logic [3:0] WORD_YCOUNT = 4'd5;
    localparam logic [3:0] WORD_YSTEP  = 4'd6;
    localparam logic [3:0] WORD_ZCOUNT = 4'd7;
    localparam logic [3:0] WORD_ZSTEP  = 4'd8;
    localparam logic [3:0] WORD_KCOUNT = 4'd9;
    localparam logic [3:0] WORD_KSTEP  = 4'd10;

    // One descriptor row as read from the table
    typedef struct packed {
        slot_t      next;
        addr_t      start;
        mode_t      mode;
        count_vec_t count;
        step_vec_t  step;
    } desc_row_t;

    // Table write request
    typedef struct packed {
        logic                  en;
        slot_t                 slot;
        logic [3:0]            word;
        logic [VALUE_BITS-1:0] value;
        slot_t                 next_slot;
    } tbl_wr_t;

    // Sequencer states
    typedef enum logic [2:0] {
        ST_IDLE,
        ST_WR_DIV,
        ST_WR_COMMIT,
        ST_READ,
        ST_EVAL,
        ST_CHAIN
    } state_t;

endpackage

`default_nettype wire

>>> design/dma_4d_descriptor_address_generator.sv
// Flow: tick, start and unused requests pass from acceptance through ST_READ and ST_EVAL
// to the result register; a tick that chains to the next descriptor adds ST_CHAIN, and a
// descriptor write first passes ST_WR_DIV and ST_WR_COMMIT. A new request is accepted only
// in ST_IDLE with the result register free; the descriptor table's registered read port is
// read once per request and once more on a chain. Reset: direction and walk state clear
// at once; the table's 16 slots are then swept clear, during which no request is accepted.
`timescale 1ns / 1ps
`default_nettype none

`include "dma_4d_descriptor_address_generator_defines.svh"

module dma_4d_descriptor_address_generator (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        in_valid,
    output logic             in_ready,
    input  wire logic [1:0]  opcode,
    input  wire logic [3:0]  desc_slot,
    input  wire logic [3:0]  desc_word,
    input  wire logic [15:0] word_value,
    output logic             out_valid,
    input  wire logic        out_ready,
    output logic [15:0]      ram_address,
    output logic [1:0]       access,
    output logic [3:0]       active_descriptor,
    output logic [1:0]       active_mode,
    input  wire logic        cfg_write_en,
    input  wire logic [0:0]  cfg_write_data
);

    d4dag_pkg::state_t     state_reg, state_next;
    logic                  direction_reg, direction_next;

    // Request latch
    logic [1:0]            op_reg, op_next;
    logic [3:0]            slot_reg, slot_next;
    logic [3:0]            word_reg, word_next;
    logic [d4dag_pkg::VALUE_BITS-1:0] value_reg, value_next;
    logic [d4dag_pkg::VALUE_BITS-1:0] quot_reg, quot_next;

    // Walk state
    d4dag_pkg::slot_t      cur_slot_reg, cur_slot_next;
    d4dag_pkg::addr_t      cur_addr_reg, cur_addr_next;
    d4dag_pkg::count_vec_t rem_reg, rem_next;

    // Result register
    logic                  out_valid_reg, out_valid_next;
    logic [15:0]           ram_address_reg, ram_address_next;
    logic [1:0]            access_reg, access_next;
    logic [3:0]            active_desc_reg, active_desc_next;
    logic [1:0]            active_mode_reg, active_mode_next;

    // Table and step unit
    d4dag_pkg::tbl_wr_t    tbl_wr;
    logic                  rd_en;
    d4dag_pkg::slot_t      rd_slot;
    d4dag_pkg::desc_row_t  rd_row;
    logic                  clear_busy;
    d4dag_pkg::addr_t      step_addr;
    d4dag_pkg::count_vec_t step_rem;
    logic                  step_done;

    // Link reduction
    logic [d4dag_pkg::MOD_PROD_BITS-1:0] prod;
    logic [d4dag_pkg::MOD_QS_BITS-1:0]   qs;
    logic [d4dag_pkg::VALUE_BITS-1:0] rem_raw;
    logic [d4dag_pkg::VALUE_BITS-1:0] rem_fix;

    logic                  accept;
    logic                  out_free;

    d4dag_desc_table u_table (
        .clk        (clk),
        .rst_n      (rst_n),
        .wr         (tbl_wr),
        .rd_en      (rd_en),
        .rd_slot    (rd_slot),
        .rd_row     (rd_row),
        .clear_busy (clear_busy)
    );

    d4dag_step_unit u_step (
        .addr           (cur_addr_reg),
        .remaining      (rem_reg),
        .count          (rd_row.count),
        .step           (rd_row.step),
        .addr_next      (step_addr),
        .remaining_next (step_rem),
        .done           (step_done)
    );

    // Link value modulo SLOTS: reciprocal multiply, then one correction
    assign prod    = d4dag_pkg::MOD_PROD_BITS'(value_reg)
                   * d4dag_pkg::MOD_PROD_BITS'(d4dag_pkg::MOD_RECIP);
    assign qs      = d4dag_pkg::MOD_QS_BITS'(d4dag_pkg::MOD_QS_BITS'(quot_reg)
                   * d4dag_pkg::MOD_QS_BITS'(d4dag_pkg::SLOTS));
    assign rem_raw = value_reg - d4dag_pkg::VALUE_BITS'(qs);
    assign rem_fix = (rem_raw >= d4dag_pkg::VALUE_BITS'(d4dag_pkg::SLOTS))
                   ? (rem_raw - d4dag_pkg::VALUE_BITS'(d4dag_pkg::SLOTS)) : rem_raw;

    assign out_free = !out_valid_reg || out_ready;
    assign accept   = in_valid && in_ready;

    // Next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            d4dag_pkg::ST_IDLE:
            begin
                if (accept)
                begin
                    state_next = (opcode == d4dag_pkg::OP_WRITE)
                               ? d4dag_pkg::ST_WR_DIV : d4dag_pkg::ST_READ;
                end
            end
            d4dag_pkg::ST_WR_DIV:    state_next = d4dag_pkg::ST_WR_COMMIT;
            d4dag_pkg::ST_WR_COMMIT: state_next = d4dag_pkg::ST_READ;
            d4dag_pkg::ST_READ:      state_next = d4dag_pkg::ST_EVAL;
            d4dag_pkg::ST_EVAL:
            begin
                if ((op_reg == d4dag_pkg::OP_TICK) &&
                    (rd_row.mode != d4dag_pkg::MODE_SUSPEND) && step_done)
                begin
                    state_next = d4dag_pkg::ST_CHAIN;
                end
                else
                begin
                    state_next = d4dag_pkg::ST_IDLE;
                end
            end
            d4dag_pkg::ST_CHAIN:     state_next = d4dag_pkg::ST_IDLE;
            default:                 state_next = d4dag_pkg::ST_IDLE;
        endcase
    end

    // Outputs and datapath
    always_comb
    begin
        in_ready         = (state_reg == d4dag_pkg::ST_IDLE) && !clear_busy && out_free;
        direction_next   = cfg_write_en ? cfg_write_data[0] : direction_reg;
        op_next          = op_reg;
        slot_next        = slot_reg;
        word_next        = word_reg;
        value_next       = value_reg;
        quot_next        = quot_reg;
        cur_slot_next    = cur_slot_reg;
        cur_addr_next    = cur_addr_reg;
        rem_next         = rem_reg;
        out_valid_next   = out_valid_reg && !out_ready;
        ram_address_next = ram_address_reg;
        access_next      = access_reg;
        active_desc_next = active_desc_reg;
        active_mode_next = active_mode_reg;
        rd_en            = 1'b0;
        rd_slot          = cur_slot_reg;
        tbl_wr.en        = 1'b0;
        tbl_wr.slot      = d4dag_pkg::SLOT_BITS'(slot_reg);
        tbl_wr.word      = word_reg;
        tbl_wr.value     = value_reg;
        tbl_wr.next_slot = d4dag_pkg::SLOT_BITS'(rem_fix);

        case (state_reg)
            d4dag_pkg::ST_IDLE:
            begin
                if (accept)
                begin
                    op_next    = opcode;
                    slot_next  = desc_slot;
                    word_next  = desc_word;
                    value_next = word_value;
                    if (opcode == d4dag_pkg::OP_START)
                    begin
                        cur_slot_next = '0;
                    end
                end
            end
            d4dag_pkg::ST_WR_DIV:
            begin
                quot_next = d4dag_pkg::VALUE_BITS'(prod >> d4dag_pkg::MOD_SHIFT);
            end
            d4dag_pkg::ST_WR_COMMIT:
            begin
                // Slots beyond the table are dropped
                tbl_wr.en = (32'(slot_reg) < 32'(d4dag_pkg::SLOTS));
            end
            d4dag_pkg::ST_READ:
            begin
                rd_en = 1'b1;
            end
            d4dag_pkg::ST_EVAL:
            begin
                ram_address_next = '0;
                access_next      = d4dag_pkg::ACC_NONE;
                active_desc_next = 4'(cur_slot_reg);
                active_mode_next = rd_row.mode;
                out_valid_next   = 1'b1;
                case (op_reg)
                    d4dag_pkg::OP_TICK:
                    begin
                        if (rd_row.mode == d4dag_pkg::MODE_SUSPEND)
                        begin
                            access_next = direction_reg ? d4dag_pkg::ACC_NONE
                                                        : d4dag_pkg::ACC_ZERO;
                        end
                        else
                        begin
                            if (rd_row.mode != d4dag_pkg::MODE_WAIT)
                            begin
                                ram_address_next = 16'(cur_addr_reg);
                                access_next      = direction_reg ? d4dag_pkg::ACC_WRITE
                                                                 : d4dag_pkg::ACC_READ;
                            end
                            cur_addr_next = step_addr;
                            rem_next      = step_rem;
                            // Walk finished: fetch the linked descriptor
                            if (step_done)
                            begin
                                out_valid_next = 1'b0;
                                rd_en          = 1'b1;
                                rd_slot        = rd_row.next;
                                cur_slot_next  = rd_row.next;
                            end
                        end
                    end
                    d4dag_pkg::OP_START:
                    begin
                        cur_addr_next = rd_row.start;
                        rem_next      = rd_row.count;
                    end
                    default:
                    begin
                    end
                endcase
            end
            d4dag_pkg::ST_CHAIN:
            begin
                if (rd_row.mode != d4dag_pkg::MODE_FORWARD)
                begin
                    cur_addr_next = rd_row.start;
                end
                rem_next         = rd_row.count;
                active_desc_next = 4'(cur_slot_reg);
                active_mode_next = rd_row.mode;
                out_valid_next   = 1'b1;
            end
            default:
            begin
            end
        endcase
    end

    // Control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= d4dag_pkg::ST_IDLE;
            direction_reg <= 1'b0;
            cur_slot_reg  <= '0;
            cur_addr_reg  <= '0;
            rem_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            direction_reg <= direction_next;
            cur_slot_reg  <= cur_slot_next;
            cur_addr_reg  <= cur_addr_next;
            rem_reg       <= rem_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // Payload registers
    always_ff @(posedge clk)
    begin
        op_reg          <= op_next;
        slot_reg        <= slot_next;
        word_reg        <= word_next;
        value_reg       <= value_next;
        quot_reg        <= quot_next;
        ram_address_reg <= ram_address_next;
        access_reg      <= access_next;
        active_desc_reg <= active_desc_next;
        active_mode_reg <= active_mode_next;
    end

    assign out_valid         = out_valid_reg;
    assign ram_address       = ram_address_reg;
    assign access            = access_reg;
    assign active_descriptor = active_desc_reg;
    assign active_mode       = active_mode_reg;

    // Checks
    `D4DAG_ASSERT_IMPL(a_accept_out_free, in_valid && in_ready, !out_valid_reg || out_ready,
        "request accepted with result register blocked")
    `D4DAG_ASSERT_IMPL(a_no_accept_clearing, clear_busy, !in_ready,
        "request accepted during table sweep")
    `D4DAG_ASSERT_IMPL(a_no_access_zero_addr,
        out_valid_reg && (access_reg == d4dag_pkg::ACC_NONE ||
                          access_reg == d4dag_pkg::ACC_ZERO),
        ram_address_reg == '0, "address shown without RAM access")
    `D4DAG_ASSERT_NEXT(a_read_then_eval, state_reg == d4dag_pkg::ST_READ,
        state_reg == d4dag_pkg::ST_EVAL, "table read not followed by evaluation")

endmodule

`default_nettype wire

>>> design/d4dag_desc_table.sv
`timescale 1ns / 1ps
`default_nettype none

module d4dag_desc_table (
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    input  wire d4dag_pkg::tbl_wr_t   wr,
    input  wire logic                 rd_en,
    input  wire d4dag_pkg::slot_t     rd_slot,
    output d4dag_pkg::desc_row_t      rd_row,
    output logic                      clear_busy
);

    // Descriptor storage, one row per slot
    d4dag_pkg::slot_t      next_mem  [d4dag_pkg::SLOTS];
    d4dag_pkg::addr_t      start_mem [d4dag_pkg::SLOTS];
    d4dag_pkg::mode_t      mode_mem  [d4dag_pkg::SLOTS];
    d4dag_pkg::count_vec_t count_mem [d4dag_pkg::SLOTS];
    d4dag_pkg::step_vec_t  step_mem  [d4dag_pkg::SLOTS];

    d4dag_pkg::desc_row_t  rd_row_reg;

    logic                  clr_active_reg, clr_active_next;
    d4dag_pkg::slot_t      clr_idx_reg, clr_idx_next;

    // Clearing sweep after reset, one row a cycle
    always_comb
    begin
        clr_active_next = clr_active_reg;
        clr_idx_next    = clr_idx_reg;
        if (clr_active_reg)
        begin
            if (clr_idx_reg == d4dag_pkg::SLOT_BITS'(d4dag_pkg::SLOTS - 1))
            begin
                clr_active_next = 1'b0;
            end
            else
            begin
                clr_idx_next = clr_idx_reg + d4dag_pkg::SLOT_BITS'(1);
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            clr_active_reg <= 1'b1;
            clr_idx_reg    <= '0;
        end
        else
        begin
            clr_active_reg <= clr_active_next;
            clr_idx_reg    <= clr_idx_next;
        end
    end

    // Write port: sweep clears a row, else one word of one slot
    always_ff @(posedge clk)
    begin
        if (clr_active_reg)
        begin
            next_mem[clr_idx_reg]  <= '0;
            start_mem[clr_idx_reg] <= '0;
            mode_mem[clr_idx_reg]  <= d4dag_pkg::MODE_SUSPEND;
            count_mem[clr_idx_reg] <= '0;
            step_mem[clr_idx_reg]  <= '0;
        end
        else if (wr.en)
        begin
            case (wr.word)
                d4dag_pkg::WORD_NEXT:   next_mem[wr.slot]  <= wr.next_slot;
                d4dag_pkg::WORD_START:
                    start_mem[wr.slot] <= d4dag_pkg::ADDR_BITS'(wr.value);
                d4dag_pkg::WORD_MODE:
                    mode_mem[wr.slot]  <= d4dag_pkg::mode_t'(wr.value[1:0]);
                d4dag_pkg::WORD_XCOUNT:
                    count_mem[wr.slot][0] <= d4dag_pkg::COUNT_BITS'(wr.value);
                d4dag_pkg::WORD_YCOUNT:
                    count_mem[wr.slot][1] <= d4dag_pkg::COUNT_BITS'(wr.value);
                d4dag_pkg::WORD_ZCOUNT:
                    count_mem[wr.slot][2] <= d4dag_pkg::COUNT_BITS'(wr.value);
                d4dag_pkg::WORD_KCOUNT:
                    count_mem[wr.slot][3] <= d4dag_pkg::COUNT_BITS'(wr.value);
                d4dag_pkg::WORD_XSTEP:
                    step_mem[wr.slot][0] <= d4dag_pkg::ADDR_BITS'(wr.value);
                d4dag_pkg::WORD_YSTEP:
                    step_mem[wr.slot][1] <= d4dag_pkg::ADDR_BITS'(wr.value);
                d4dag_pkg::WORD_ZSTEP:
                    step_mem[wr.slot][2] <= d4dag_pkg::ADDR_BITS'(wr.value);
                d4dag_pkg::WORD_KSTEP:
                    step_mem[wr.slot][3] <= d4dag_pkg::ADDR_BITS'(wr.value);
                default:
                begin
                end
            endcase
        end
    end

    // Registered read port, loaded while rd_en is high
    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            rd_row_reg.next  <= next_mem[rd_slot];
            rd_row_reg.start <= start_mem[rd_slot];
            rd_row_reg.mode  <= mode_mem[rd_slot];
            rd_row_reg.count <= count_mem[rd_slot];
            rd_row_reg.step  <= step_mem[rd_slot];
        end
    end

    assign rd_row     = rd_row_reg;
    assign clear_busy = clr_active_reg;

endmodule

`default_nettype wire

>>> design/d4dag_step_unit.sv
`timescale 1ns / 1ps
`default_nettype none

module d4dag_step_unit (
    input  wire d4dag_pkg::addr_t       addr,
    input  wire d4dag_pkg::count_vec_t  remaining,
    input  wire d4dag_pkg::count_vec_t  count,
    input  wire d4dag_pkg::step_vec_t   step,
    output d4dag_pkg::addr_t            addr_next,
    output d4dag_pkg::count_vec_t       remaining_next,
    output logic                        done
);

    logic found;

    // Innermost live dimension steps; inner ones reload
    always_comb
    begin
        found          = 1'b0;
        addr_next      = addr;
        remaining_next = remaining;
        for (int d = 0; d < d4dag_pkg::DIMS; d++)
        begin
            if (!found && (remaining[d] != '0))
            begin
                found     = 1'b1;
                addr_next = addr + step[d];
                for (int i = 0; i < d4dag_pkg::DIMS; i++)
                begin
                    if (i < d)
                    begin
                        remaining_next[i] = count[i];
                    end
                end
                remaining_next[d] = remaining[d] - d4dag_pkg::COUNT_BITS'(1);
            end
        end
        done = (remaining_next == '0);
    end

endmodule

`default_nettype wire
